// ===== rtl/core/rbst_pkg.sv =====
// Shared types and constants of the ray/box slab test.
package rbst_pkg;

    localparam int NUM_AXES  = 3;
    localparam int NUM_LANES = 2 * NUM_AXES;

    // Control that travels down the pipeline next to the lane data
    typedef struct packed {
        logic                valid;
        logic                miss;
        logic [NUM_AXES-1:0] skip;
    } ctl_t;

endpackage

// ===== rtl/core/rbst_if.sv =====
// Channel interfaces of the ray/box slab test: ray and box in, hit result out.
interface rbst_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [FRAC_BITS+1:0]   dir_x;
    logic signed [FRAC_BITS+1:0]   dir_y;
    logic signed [FRAC_BITS+1:0]   dir_z;
    logic signed [COORD_WIDTH-1:0] box_low_x;
    logic signed [COORD_WIDTH-1:0] box_low_y;
    logic signed [COORD_WIDTH-1:0] box_low_z;
    logic signed [COORD_WIDTH-1:0] box_high_x;
    logic signed [COORD_WIDTH-1:0] box_high_y;
    logic signed [COORD_WIDTH-1:0] box_high_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
        output ready
    );
endinterface

interface rbst_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [COORD_WIDTH-2:0] entry_distance;

    modport source (output valid, hit, entry_distance, input ready);
    modport sink   (input valid, hit, entry_distance, output ready);
endinterface

// ===== rtl/core/rbst_div_step.sv =====
// One registered restoring-division step for all six slab lanes.
module rbst_div_step #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  rbst_pkg::ctl_t         ctl_in,
    input  logic [FRAC_BITS+1:0]   r_in    [rbst_pkg::NUM_LANES],
    input  logic [COORD_WIDTH-1:0] w_in    [rbst_pkg::NUM_LANES],
    input  logic [FRAC_BITS+1:0]   dmag_in [rbst_pkg::NUM_LANES],
    input  logic                   sat_in  [rbst_pkg::NUM_LANES],
    input  logic                   neg_in  [rbst_pkg::NUM_LANES],
    output rbst_pkg::ctl_t         ctl_out,
    output logic [FRAC_BITS+1:0]   r_out    [rbst_pkg::NUM_LANES],
    output logic [COORD_WIDTH-1:0] w_out    [rbst_pkg::NUM_LANES],
    output logic [FRAC_BITS+1:0]   dmag_out [rbst_pkg::NUM_LANES],
    output logic                   sat_out  [rbst_pkg::NUM_LANES],
    output logic                   neg_out  [rbst_pkg::NUM_LANES]
);
    localparam int DW = FRAC_BITS + 2;
    localparam int NL = rbst_pkg::NUM_LANES;

    rbst_pkg::ctl_t         ctl_reg;
    logic [DW-1:0]          r_reg    [NL];
    logic [DW-1:0]          r_next   [NL];
    logic [COORD_WIDTH-1:0] w_reg    [NL];
    logic [COORD_WIDTH-1:0] w_next   [NL];
    logic [DW-1:0]          dmag_reg [NL];
    logic                   sat_reg  [NL];
    logic                   neg_reg  [NL];

    // Bring down the next numerator bit; subtract the divisor when it fits
    always_comb
    begin
        logic [DW:0] part;
        logic [DW:0] diff;
        logic        ge;
        for (int l = 0; l < NL; l++)
        begin
            part      = {r_in[l], w_in[l][COORD_WIDTH-1]};
            diff      = part - {1'b0, dmag_in[l]};
            ge        = (part >= {1'b0, dmag_in[l]});
            r_next[l] = ge ? diff[DW-1:0] : part[DW-1:0];
            w_next[l] = {w_in[l][COORD_WIDTH-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NL; l++)
            begin
                r_reg[l]    <= r_next[l];
                w_reg[l]    <= w_next[l];
                dmag_reg[l] <= dmag_in[l];
                sat_reg[l]  <= sat_in[l];
                neg_reg[l]  <= neg_in[l];
            end
        end
    end

    assign ctl_out  = ctl_reg;
    assign r_out    = r_reg;
    assign w_out    = w_reg;
    assign dmag_out = dmag_reg;
    assign sat_out  = sat_reg;
    assign neg_out  = neg_reg;
endmodule

// ===== rtl/core/rbst_divider.sv =====
// Pipelined saturating Q-format divider for the six slab distances.
module rbst_divider #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  rbst_pkg::ctl_t                ctl_in,
    input  logic [COORD_WIDTH-1:0]        nmag_in [rbst_pkg::NUM_LANES],
    input  logic [FRAC_BITS+1:0]          dmag_in [rbst_pkg::NUM_LANES],
    input  logic                          neg_in  [rbst_pkg::NUM_LANES],
    output rbst_pkg::ctl_t                ctl_out,
    output logic signed [COORD_WIDTH-1:0] q_out   [rbst_pkg::NUM_LANES]
);
    localparam int DW = FRAC_BITS + 2;
    localparam int NL = rbst_pkg::NUM_LANES;
    localparam int NW = COORD_WIDTH + FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] LIM_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] LIM_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    rbst_pkg::ctl_t         ctl_s  [COORD_WIDTH+1];
    logic [DW-1:0]          r_s    [COORD_WIDTH+1][NL];
    logic [COORD_WIDTH-1:0] w_s    [COORD_WIDTH+1][NL];
    logic [DW-1:0]          dmag_s [COORD_WIDTH+1][NL];
    logic                   sat_s  [COORD_WIDTH+1][NL];
    logic                   neg_s  [COORD_WIDTH+1][NL];

    rbst_pkg::ctl_t         ctl_init_reg;
    logic [DW-1:0]          r_init_next [NL];
    logic [COORD_WIDTH-1:0] w_init_next [NL];
    logic                   sat_init_next [NL];
    logic [DW-1:0]          r_init_reg [NL];
    logic [COORD_WIDTH-1:0] w_init_reg [NL];
    logic [DW-1:0]          dmag_init_reg [NL];
    logic                   sat_init_reg [NL];
    logic                   neg_init_reg [NL];

    rbst_pkg::ctl_t                ctl_fin_reg;
    logic signed [COORD_WIDTH-1:0] q_fin_next [NL];
    logic signed [COORD_WIDTH-1:0] q_fin_reg  [NL];

    // Split the scaled numerator: the upper part decides overflow, the lower
    // part feeds the bit steps
    always_comb
    begin
        logic [NW-1:0]        num;
        logic [FRAC_BITS-1:0] top;
        for (int l = 0; l < NL; l++)
        begin
            num              = {nmag_in[l], {FRAC_BITS{1'b0}}};
            top              = num[NW-1:COORD_WIDTH];
            sat_init_next[l] = ({2'b00, top} >= dmag_in[l]);
            r_init_next[l]   = sat_init_next[l] ? '0 : {2'b00, top};
            w_init_next[l]   = num[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_init_reg <= '0;
            ctl_fin_reg  <= '0;
        end
        else if (en)
        begin
            ctl_init_reg <= ctl_in;
            ctl_fin_reg  <= ctl_s[COORD_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NL; l++)
            begin
                r_init_reg[l]    <= r_init_next[l];
                w_init_reg[l]    <= w_init_next[l];
                dmag_init_reg[l] <= dmag_in[l];
                sat_init_reg[l]  <= sat_init_next[l];
                neg_init_reg[l]  <= neg_in[l];
                q_fin_reg[l]     <= q_fin_next[l];
            end
        end
    end

    assign ctl_s[0]  = ctl_init_reg;
    assign r_s[0]    = r_init_reg;
    assign w_s[0]    = w_init_reg;
    assign dmag_s[0] = dmag_init_reg;
    assign sat_s[0]  = sat_init_reg;
    assign neg_s[0]  = neg_init_reg;

    for (genvar i = 0; i < COORD_WIDTH; i++)
    begin : g_step
        rbst_div_step #(
            .COORD_WIDTH(COORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_s[i]),
            .r_in    (r_s[i]),
            .w_in    (w_s[i]),
            .dmag_in (dmag_s[i]),
            .sat_in  (sat_s[i]),
            .neg_in  (neg_s[i]),
            .ctl_out (ctl_s[i+1]),
            .r_out   (r_s[i+1]),
            .w_out   (w_s[i+1]),
            .dmag_out(dmag_s[i+1]),
            .sat_out (sat_s[i+1]),
            .neg_out (neg_s[i+1])
        );
    end

    // Clamp to the signed range, then apply the sign
    always_comb
    begin
        logic [COORD_WIDTH-1:0] lim;
        logic [COORD_WIDTH-1:0] qs;
        for (int l = 0; l < NL; l++)
        begin
            lim = neg_s[COORD_WIDTH][l] ? LIM_NEG : LIM_POS;
            qs  = (sat_s[COORD_WIDTH][l] || (w_s[COORD_WIDTH][l] > lim))
                  ? lim : w_s[COORD_WIDTH][l];
            q_fin_next[l] = neg_s[COORD_WIDTH][l] ? $signed(-qs) : $signed(qs);
        end
    end

    assign ctl_out = ctl_fin_reg;
    assign q_out   = q_fin_reg;
endmodule

// ===== rtl/core/ray_box_slab_test_core.sv =====
// Top level of the pipelined ray versus axis-aligned box slab test.
//
// Each transfer on ray_in carries one ray (origin, unit direction) and one
// box (low and high corners) in signed fixed point; exactly one transfer on
// result comes back per input, in order, with hit and the entry distance
// (clamped at zero, zero on a miss). The block takes one test every cycle
// unless a stall on result holds it. Most of the pipeline depth is in the
// divider, which retires one quotient bit per stage for six slab distances
// in parallel. The whole pipeline advances together whenever the output
// register is empty or being drained, so a stall on result holds every
// stage in place.
module ray_box_slab_test_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    rbst_in_if.sink         ray_in,
    rbst_out_if.source      result
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = FRAC_BITS + 2;
    localparam int NA = rbst_pkg::NUM_AXES;
    localparam int NL = rbst_pkg::NUM_LANES;
    localparam logic signed [CW-1:0] NEAR_INIT = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] FAR_INIT  = {1'b0, {(CW-1){1'b1}}};

    logic adv;

    // Stage 1: differences, magnitudes, signs, zero-direction checks
    logic signed [CW-1:0] org [NA];
    logic signed [DW-1:0] dir [NA];
    logic signed [CW-1:0] blo [NA];
    logic signed [CW-1:0] bhi [NA];

    rbst_pkg::ctl_t  s1_ctl_reg;
    rbst_pkg::ctl_t  s1_ctl_next;
    logic [CW-1:0]   s1_nmag_reg [NL];
    logic [CW-1:0]   s1_nmag_next [NL];
    logic [DW-1:0]   s1_dmag_reg [NL];
    logic [DW-1:0]   s1_dmag_next [NL];
    logic            s1_neg_reg [NL];
    logic            s1_neg_next [NL];

    // Divider output
    rbst_pkg::ctl_t        dv_ctl;
    logic signed [CW-1:0]  dv_q [NL];

    // Stage 3: ordered near/far per axis
    rbst_pkg::ctl_t        s3_ctl_reg;
    logic signed [CW-1:0]  s3_tn_reg [NA];
    logic signed [CW-1:0]  s3_tf_reg [NA];
    logic signed [CW-1:0]  s3_tn_next [NA];
    logic signed [CW-1:0]  s3_tf_next [NA];

    // Stage 4: reduced near/far
    rbst_pkg::ctl_t        s4_ctl_reg;
    logic signed [CW-1:0]  s4_near_reg;
    logic signed [CW-1:0]  s4_far_reg;
    logic signed [CW-1:0]  s4_near_next;
    logic signed [CW-1:0]  s4_far_next;

    // Output register
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [CW-2:0]         out_entry_reg;
    logic                  out_hit_next;
    logic [CW-2:0]         out_entry_next;

    // Advance everything when the output slot is free or being taken
    assign adv          = !out_valid_reg || result.ready;
    assign ray_in.ready = adv;

    assign org[0] = ray_in.origin_x;
    assign org[1] = ray_in.origin_y;
    assign org[2] = ray_in.origin_z;
    assign dir[0] = ray_in.dir_x;
    assign dir[1] = ray_in.dir_y;
    assign dir[2] = ray_in.dir_z;
    assign blo[0] = ray_in.box_low_x;
    assign blo[1] = ray_in.box_low_y;
    assign blo[2] = ray_in.box_low_z;
    assign bhi[0] = ray_in.box_high_x;
    assign bhi[1] = ray_in.box_high_y;
    assign bhi[2] = ray_in.box_high_z;

    // Lane 2a is the low bound of axis a, lane 2a+1 the high bound.
    // A zero direction skips the axis, or misses when the origin sits outside.
    always_comb
    begin
        logic signed [CW:0] dlo;
        logic signed [CW:0] dhi;
        logic [CW:0]        alo;
        logic [CW:0]        ahi;
        logic               dneg;
        logic [DW-1:0]      dmag;
        logic               dzero;
        logic               in_slab;
        s1_ctl_next       = '0;
        s1_ctl_next.valid = ray_in.valid;
        for (int a = 0; a < NA; a++)
        begin
            dlo     = CW'(0) + {blo[a][CW-1], blo[a]} - {org[a][CW-1], org[a]};
            dhi     = {bhi[a][CW-1], bhi[a]} - {org[a][CW-1], org[a]};
            alo     = dlo[CW] ? -dlo : dlo;
            ahi     = dhi[CW] ? -dhi : dhi;
            dneg    = dir[a][DW-1];
            dmag    = dneg ? -dir[a] : dir[a];
            dzero   = (dir[a] == '0);
            in_slab = (org[a] >= blo[a]) && (bhi[a] >= org[a]);
            s1_nmag_next[2*a]   = alo[CW-1:0];
            s1_nmag_next[2*a+1] = ahi[CW-1:0];
            s1_dmag_next[2*a]   = dzero ? DW'(1) : dmag;
            s1_dmag_next[2*a+1] = dzero ? DW'(1) : dmag;
            s1_neg_next[2*a]    = dlo[CW] ^ dneg;
            s1_neg_next[2*a+1]  = dhi[CW] ^ dneg;
            s1_ctl_next.skip[a] = dzero;
            if (dzero && !in_slab)
            begin
                s1_ctl_next.miss = 1'b1;
            end
        end
    end

    // Order the two crossings of each axis
    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            if (dv_q[2*a] < dv_q[2*a+1])
            begin
                s3_tn_next[a] = dv_q[2*a];
                s3_tf_next[a] = dv_q[2*a+1];
            end
            else
            begin
                s3_tn_next[a] = dv_q[2*a+1];
                s3_tf_next[a] = dv_q[2*a];
            end
        end
    end

    // Keep the latest entry and earliest exit over the constrained axes
    always_comb
    begin
        s4_near_next = NEAR_INIT;
        s4_far_next  = FAR_INIT;
        for (int a = 0; a < NA; a++)
        begin
            if (!s3_ctl_reg.skip[a])
            begin
                if (s4_near_next < s3_tn_reg[a])
                begin
                    s4_near_next = s3_tn_reg[a];
                end
                if (s3_tf_reg[a] < s4_far_next)
                begin
                    s4_far_next = s3_tf_reg[a];
                end
            end
        end
    end

    // Final verdict and entry clamp
    always_comb
    begin
        out_hit_next = !s4_ctl_reg.miss && !(s4_far_reg < s4_near_reg)
                       && !s4_far_reg[CW-1];
        if (out_hit_next && !s4_near_reg[CW-1])
        begin
            out_entry_next = s4_near_reg[CW-2:0];
        end
        else
        begin
            out_entry_next = '0;
        end
    end

    rbst_divider #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .ctl_in (s1_ctl_reg),
        .nmag_in(s1_nmag_reg),
        .dmag_in(s1_dmag_reg),
        .neg_in (s1_neg_reg),
        .ctl_out(dv_ctl),
        .q_out  (dv_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg    <= '0;
            s3_ctl_reg    <= '0;
            s4_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_ctl_reg    <= s1_ctl_next;
            s3_ctl_reg    <= dv_ctl;
            s4_ctl_reg    <= s3_ctl_reg;
            out_valid_reg <= s4_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < NL; l++)
            begin
                s1_nmag_reg[l] <= s1_nmag_next[l];
                s1_dmag_reg[l] <= s1_dmag_next[l];
                s1_neg_reg[l]  <= s1_neg_next[l];
            end
            for (int a = 0; a < NA; a++)
            begin
                s3_tn_reg[a] <= s3_tn_next[a];
                s3_tf_reg[a] <= s3_tf_next[a];
            end
            s4_near_reg   <= s4_near_next;
            s4_far_reg    <= s4_far_next;
            out_hit_reg   <= out_hit_next;
            out_entry_reg <= out_entry_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.hit            = out_hit_reg;
    assign result.entry_distance = out_entry_reg;

    // A miss always reports a zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_hit_reg |-> out_entry_reg == '0)
        else $error("miss with nonzero entry distance");

    // A flagged miss in the last stage never turns into a hit
    a_miss_kept: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s4_ctl_reg.valid && s4_ctl_reg.miss |=> !out_hit_reg)
        else $error("zero-direction miss lost");

    // A stalled result stays in the output register
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_entry_reg))
        else $error("result dropped during stall");
endmodule

// ===== bench/tb_ray_box_slab_test_core.sv =====
// Testbench of the ray/box slab test core: random and directed rays checked against a predictor.
`timescale 1ns / 1ps

module tb_ray_box_slab_test_core;

    localparam int CW      = 32;
    localparam int FB      = 16;
    localparam int DW      = FB + 2;
    localparam int LATENCY = CW + 6;
    localparam int N_RAND  = 1330;
    localparam longint LIMIT = 400000;

    // One ray/box test as it travels on the input channel
    typedef struct packed {
        logic signed [CW-1:0] ox, oy, oz;
        logic signed [DW-1:0] dx, dy, dz;
        logic signed [CW-1:0] lx, ly, lz;
        logic signed [CW-1:0] hx, hy, hz;
    } ray_box_t;

    typedef struct packed {
        logic          hit;
        logic [CW-2:0] entry;
    } hit_rec_t;

    logic clk;
    logic rst_n;

    rbst_in_if  #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) ray_in ();
    rbst_out_if #(.COORD_WIDTH(CW))                 result ();

    ray_box_slab_test_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .ray_in (ray_in.sink),
        .result (result.source)
    );

    ray_box_t pending_rays[$];
    hit_rec_t expected_hits[$];
    int       errors;
    bit       stim_done;
    bit       hold_sender;    // sender pauses until the pipeline drains
    bit       long_stall_req; // not driven; the receiver's long hold-off is counted in long_stall_cnt
    bit       in_taken;       // the offer was accepted at the last rising edge
    longint   cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: saturating fixed-point slab distance (b - o) / d, d != 0
    // ------------------------------------------------------------------
    function automatic longint slab_distance(longint b, longint o, longint d);
        longint num, nmag, dmag, ip, rem, q, lim;
        bit     neg;
        num  = b - o;
        nmag = (num < 0) ? -num : num;
        dmag = (d < 0) ? -d : d;
        neg  = (num < 0) != (d < 0);
        lim  = neg ? (64'sd1 <<< (CW - 1)) : ((64'sd1 <<< (CW - 1)) - 1);
        ip   = nmag / dmag;
        rem  = nmag % dmag;
        if (ip > (lim >>> FB))
            q = lim;
        else
        begin
            q = (ip <<< FB) + ((rem <<< FB) / dmag);
            if (q > lim)
                q = lim;
        end
        return neg ? -q : q;
    endfunction

    function automatic hit_rec_t predict_hit(ray_box_t r);
        longint   o[3], d[3], lo[3], hi[3];
        longint   t1, t2, tn, tf, near_t, far_t;
        bit       ok;
        hit_rec_t res;
        o  = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
        d  = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
        lo = '{longint'(r.lx), longint'(r.ly), longint'(r.lz)};
        hi = '{longint'(r.hx), longint'(r.hy), longint'(r.hz)};
        near_t = -(64'sd1 <<< (CW - 1));
        far_t  = (64'sd1 <<< (CW - 1)) - 1;
        ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (d[a] == 0)
            begin
                // a flat axis constrains nothing, unless the origin is outside
                if (o[a] < lo[a] || o[a] > hi[a])
                    ok = 1'b0;
            end
            else
            begin
                t1 = slab_distance(lo[a], o[a], d[a]);
                t2 = slab_distance(hi[a], o[a], d[a]);
                tn = (t1 < t2) ? t1 : t2;
                tf = (t1 < t2) ? t2 : t1;
                if (tn > near_t)
                    near_t = tn;
                if (tf < far_t)
                    far_t = tf;
            end
        end
        if (ok && (far_t < near_t || far_t < 0))
            ok = 1'b0;
        res.hit   = ok;
        res.entry = (ok && near_t > 0) ? near_t[CW-2:0] : '0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [DW-1:0] rand_dir();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 18'sd65536;
            2:       return -18'sd65536;
            3:       return DW'($urandom_range(0, 255) - 128);  // tiny: saturating quotients
            4:       return DW'($urandom());                     // any pattern, all bits
            default: return DW'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return {1'b0, {(CW-1){1'b1}}};
            2:       return {1'b1, {(CW-1){1'b0}}};
            default: return $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
        endcase
    endfunction

    // Mostly well-formed boxes near the ray, some swapped or far-off
    function automatic ray_box_t rand_ray_box();
        ray_box_t r;
        logic signed [CW-1:0] a, b;
        r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
        r.dx = rand_dir();   r.dy = rand_dir();   r.dz = rand_dir();
        for (int i = 0; i < 3; i++)
        begin
            a = rand_coord();
            b = rand_coord();
            if ($urandom_range(0, 3) != 0 && a > b)
            begin
                a = a ^ b; b = a ^ b; a = a ^ b;
            end
            case (i)
                0: begin r.lx = a; r.hx = b; end
                1: begin r.ly = a; r.hy = b; end
                default: begin r.lz = a; r.hz = b; end
            endcase
        end
        return r;
    endfunction

    function automatic ray_box_t make_ray(longint ox, longint oy, longint oz,
                                          longint dx, longint dy, longint dz,
                                          longint lo, longint hi);
        ray_box_t r;
        r.ox = CW'(ox); r.oy = CW'(oy); r.oz = CW'(oz);
        r.dx = DW'(dx); r.dy = DW'(dy); r.dz = DW'(dz);
        r.lx = CW'(lo); r.ly = CW'(lo); r.lz = CW'(lo);
        r.hx = CW'(hi); r.hy = CW'(hi); r.hz = CW'(hi);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: directed cases first, then random bursts
    // ------------------------------------------------------------------
    localparam longint ONE  = 65536;
    localparam longint MAXC = 64'sd2147483647;
    localparam longint MINC = -64'sd2147483648;

    initial
    begin
        ray_box_t r;
        errors      = 0;
        stim_done   = 1'b0;
        hold_sender = 1'b0;
        // hit from outside along +x
        pending_rays.push_back(make_ray(-10*ONE, 0, 0, ONE, 0, 0, -ONE, ONE));
        // box behind the origin
        pending_rays.push_back(make_ray(10*ONE, 0, 0, ONE, 0, 0, -ONE, ONE));
        // negative direction hit
        pending_rays.push_back(make_ray(10*ONE, 0, 0, -ONE, 0, 0, -ONE, ONE));
        // origin in the box, all directions zero: hit at zero
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, -ONE, ONE));
        // zero direction, origin on the bound
        pending_rays.push_back(make_ray(ONE, ONE, ONE, 0, 0, 0, -ONE, ONE));
        // zero direction, origin outside
        pending_rays.push_back(make_ray(2*ONE, 0, 0, 0, ONE, 0, -ONE, ONE));
        // swapped corners, nonzero and zero direction
        pending_rays.push_back(make_ray(-5*ONE, 0, 0, ONE, ONE, ONE, ONE, -ONE));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, ONE, -ONE));
        // direction outside the unit range, extreme direction codes
        pending_rays.push_back(make_ray(-3*ONE, -3*ONE, -3*ONE, 131071, 131071, 131071, -ONE, ONE));
        pending_rays.push_back(make_ray(3*ONE, 3*ONE, 3*ONE, -131072, -131072, -131072, -ONE, ONE));
        // saturating quotients with the smallest directions
        pending_rays.push_back(make_ray(MINC, MINC, MINC, 1, 1, 1, MINC, MAXC));
        pending_rays.push_back(make_ray(MAXC, MAXC, MAXC, -1, -1, -1, MINC, MAXC));
        pending_rays.push_back(make_ray(MINC, 0, 0, 1, 0, 0, MAXC, MAXC));
        // extremes of the coordinates
        pending_rays.push_back(make_ray(MAXC, MINC, MAXC, ONE, -ONE, 1, MINC, MAXC));
        pending_rays.push_back(make_ray(0, 0, 0, ONE, ONE, ONE, MAXC, MAXC));
        pending_rays.push_back(make_ray(0, 0, 0, -ONE, -ONE, -ONE, MINC, MINC));
        // grazing: near equals far
        pending_rays.push_back(make_ray(-ONE, -ONE, 0, ONE, ONE, 0, 0, 0));
        for (int i = 0; i < N_RAND; i++)
        begin
            r = rand_ray_box();
            pending_rays.push_back(r);
            // once in the middle: drain everything before going on
            if (i == N_RAND / 2)
            begin
                wait (pending_rays.size() == 0);
                hold_sender = 1'b1;
                wait (!ray_in.valid && expected_hits.size() == 0);
                @(negedge clk);
                hold_sender = 1'b0;
            end
        end
        wait (pending_rays.size() == 0);
        stim_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of random length with random gaps; change at negedge
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_in.valid <= 1'b0;
            ray_in.origin_x <= '0; ray_in.origin_y <= '0; ray_in.origin_z <= '0;
            ray_in.dir_x <= '0; ray_in.dir_y <= '0; ray_in.dir_z <= '0;
            ray_in.box_low_x <= '0; ray_in.box_low_y <= '0; ray_in.box_low_z <= '0;
            ray_in.box_high_x <= '0; ray_in.box_high_y <= '0; ray_in.box_high_z <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!ray_in.valid || in_taken)
        begin
            // the previous offer was taken (or none stood): pick the next
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 60);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (burst_left > 0 && pending_rays.size() > 0 && !hold_sender)
            begin
                ray_box_t r;
                r = pending_rays.pop_front();
                burst_left--;
                ray_in.valid      <= 1'b1;
                ray_in.origin_x   <= r.ox; ray_in.origin_y   <= r.oy; ray_in.origin_z   <= r.oz;
                ray_in.dir_x      <= r.dx; ray_in.dir_y      <= r.dy; ray_in.dir_z      <= r.dz;
                ray_in.box_low_x  <= r.lx; ray_in.box_low_y  <= r.ly; ray_in.box_low_z  <= r.lz;
                ray_in.box_high_x <= r.hx; ray_in.box_high_y <= r.hy; ray_in.box_high_z <= r.hz;
            end
            else
            begin
                ray_in.valid <= 1'b0;
                if (burst_left == 0 && gap_left > 0)
                    gap_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: periodic duty cycle plus one long hold-off
    // ------------------------------------------------------------------
    int stall_phase;
    int long_stall_cnt;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready   <= 1'b0;
            stall_phase    = 0;
            long_stall_cnt = 0;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 64;
            if (cycle_count == 500)
                long_stall_cnt = 4 * LATENCY;
            if (long_stall_cnt > 0)
            begin
                long_stall_cnt--;
                result.ready <= 1'b0;
            end
            else if (stall_phase < 24)
                result.ready <= 1'b1;                         // no idling here
            else
                result.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: record accepted inputs, check accepted results at posedge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken <= ray_in.valid && ray_in.ready;
        if (rst_n)
        begin
            if (ray_in.valid && ray_in.ready)
            begin
                ray_box_t r;
                r.ox = ray_in.origin_x; r.oy = ray_in.origin_y; r.oz = ray_in.origin_z;
                r.dx = ray_in.dir_x;    r.dy = ray_in.dir_y;    r.dz = ray_in.dir_z;
                r.lx = ray_in.box_low_x;  r.ly = ray_in.box_low_y;  r.lz = ray_in.box_low_z;
                r.hx = ray_in.box_high_x; r.hy = ray_in.box_high_y; r.hz = ray_in.box_high_z;
                expected_hits.push_back(predict_hit(r));
            end
            if (result.valid && result.ready)
            begin
                hit_rec_t exp_h;
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result transfer: hit=%0b entry=%0h",
                             $time, result.hit, result.entry_distance);
                    errors++;
                end
                else
                begin
                    exp_h = expected_hits.pop_front();
                    if (result.hit !== exp_h.hit)
                    begin
                        $display("%0t: hit mismatch: expected %0b actual %0b",
                                 $time, exp_h.hit, result.hit);
                        errors++;
                    end
                    if (result.entry_distance !== exp_h.entry)
                    begin
                        $display("%0t: entry_distance mismatch: expected %0h actual %0h",
                                 $time, exp_h.entry, result.entry_distance);
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reset, cycle limit and end of run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done);
        @(negedge clk);
        wait (!ray_in.valid && expected_hits.size() == 0);
        // let any stray result show up
        repeat (2 * LATENCY) @(posedge clk);
        if (errors == 0 && expected_hits.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
